// File: rtl/hvgc_pkg.sv
// ----------------------------------------------------------------------------
// hvgc_pkg
// Shared types and constants for the HSV value gamma correction core.
// ----------------------------------------------------------------------------
package hvgc_pkg;

    localparam int TABLE_STEPS_DEF = 100;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  table_index;
        logic [16:0] table_value;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } hvgc_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       grey_passed;
    } hvgc_out_t;

endpackage

// File: rtl/hsv_value_gamma_correct_core.sv
// ----------------------------------------------------------------------------
// hsv_value_gamma_correct_core
// Hexcone HSV conversion, gamma table lookup on value, RGB rebuild.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_data  (hvgc_in_t)
//  m_       out        m_valid / m_ready  m_data  (hvgc_out_t)
//
//  One item per cycle sustained unless m_ready stalls; a pixel passes from
//  the input register through dv_reg[0], the 17 stages of the two quotient
//  pipelines, pr_reg and ch_reg to the output register.
//  Table load items update the table as they leave in_reg and give no item.
//  Reset (aresetn low, synchronous) empties all stages; the table is unset.
//  Each stage moves on when the next one is empty or moving, so bubbles close
//  up and new items enter while a result waits on m_ready.
// ----------------------------------------------------------------------------
module hsv_value_gamma_correct_core #(
    parameter int TABLE_STEPS = hvgc_pkg::TABLE_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hvgc_pkg::hvgc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hvgc_pkg::hvgc_out_t m_data
);
    import hvgc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_STEPS + 1);
    localparam int NDIV  = 17;
    localparam int NS    = NDIV + 4;

    typedef struct packed {
        logic        grey;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  hi;
        logic [7:0]  span;
        logic [2:0]  sext;
        logic [16:0] vg;
        logic [7:0]  s_rem;
        logic [16:0] s_q;
        logic [7:0]  f_rem;
        logic [16:0] f_q;
    } dv_t;

    typedef struct packed {
        logic        grey;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  sext;
        logic [16:0] s;
        logic [16:0] vg;
        logic [32:0] sf;
        logic [32:0] sr;
    } pr_t;

    typedef struct packed {
        logic        grey;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0][33:0] ph;
        logic [2:0][32:0] pl;
    } ch_t;

    logic [NS:0]      v_reg;
    logic [NS:0]      rdy;
    hvgc_in_t         in_reg;
    dv_t              dv_reg  [NDIV+1];
    dv_t              dv0_next;
    dv_t              dv_next [1:NDIV];
    pr_t              pr_reg, pr_next;
    ch_t              ch_reg, ch_next;
    hvgc_out_t        out_reg, out_next;
    logic [16:0]      gamma_mem [TABLE_STEPS+1];
    logic [16:0]      mem_rd_reg;
    logic [IDX_W-1:0] idx_lut [256];
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;

    always_comb begin
        for (int i = 0; i < 256; i++) begin
            idx_lut[i] = IDX_W'((i * TABLE_STEPS) / 255);
        end
    end

    always_comb begin
        rdy[NS] = !v_reg[NS] || m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NS];
    assign m_data  = out_reg;

    // front end: max, min, sextant and numerator
    always_comb begin
        logic [7:0] r, g, b, hi, lo, num;
        logic [2:0] sx;
        r = in_reg.red_in;
        g = in_reg.green_in;
        b = in_reg.blue_in;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        if (r == hi) begin
            if (g == lo) begin
                sx = 3'd5; num = hi - b;
            end else begin
                sx = 3'd0; num = g - lo;
            end
        end else if (g == hi) begin
            if (b == lo) begin
                sx = 3'd1; num = hi - r;
            end else begin
                sx = 3'd2; num = b - lo;
            end
        end else begin
            if (r == lo) begin
                sx = 3'd3; num = hi - g;
            end else begin
                sx = 3'd4; num = r - lo;
            end
        end
        rd_idx         = idx_lut[hi];
        dv0_next.grey  = (hi == lo);
        dv0_next.red   = r;
        dv0_next.green = g;
        dv0_next.blue  = b;
        dv0_next.hi    = hi;
        dv0_next.span  = hi - lo;
        dv0_next.sext  = sx;
        dv0_next.vg    = '0;
        dv0_next.s_rem = hi - lo;
        dv0_next.s_q   = '0;
        dv0_next.f_rem = num;
        dv0_next.f_q   = '0;
        wr_en = v_reg[0] && rdy[1] && (in_reg.opcode == OP_LOAD)
                && (32'(in_reg.table_index) <= TABLE_STEPS);
    end

    // quotient pipelines: one bit of S and F per stage
    always_comb begin
        logic [8:0] st, ft;
        logic       sb, fb;
        for (int k = 0; k < NDIV; k++) begin
            dv_next[k+1] = dv_reg[k];
            if (k == 0) begin
                dv_next[k+1].vg = (mem_rd_reg > ONE_Q16) ? ONE_Q16 : mem_rd_reg;
            end
            st = (k == 0) ? {1'b0, dv_reg[k].s_rem} : {dv_reg[k].s_rem, 1'b0};
            ft = (k == 0) ? {1'b0, dv_reg[k].f_rem} : {dv_reg[k].f_rem, 1'b0};
            sb = (st >= {1'b0, dv_reg[k].hi});
            fb = (ft >= {1'b0, dv_reg[k].span});
            dv_next[k+1].s_rem = sb ? 8'(st - {1'b0, dv_reg[k].hi}) : st[7:0];
            dv_next[k+1].f_rem = fb ? 8'(ft - {1'b0, dv_reg[k].span}) : ft[7:0];
            dv_next[k+1].s_q   = {dv_reg[k].s_q[15:0], sb};
            dv_next[k+1].f_q   = {dv_reg[k].f_q[15:0], fb};
        end
    end

    // carry a full sextant, form the S*F products
    always_comb begin
        logic [15:0] f;
        logic [2:0]  sx;
        if (dv_reg[NDIV].f_q[16]) begin
            sx = (dv_reg[NDIV].sext == 3'd5) ? 3'd0 : dv_reg[NDIV].sext + 3'd1;
            f  = '0;
        end else begin
            sx = dv_reg[NDIV].sext;
            f  = dv_reg[NDIV].f_q[15:0];
        end
        pr_next.grey  = dv_reg[NDIV].grey;
        pr_next.red   = dv_reg[NDIV].red;
        pr_next.green = dv_reg[NDIV].green;
        pr_next.blue  = dv_reg[NDIV].blue;
        pr_next.sext  = sx;
        pr_next.s     = dv_reg[NDIV].s_q;
        pr_next.vg    = dv_reg[NDIV].vg;
        pr_next.sf    = 33'(34'(dv_reg[NDIV].s_q) * 34'(f));
        pr_next.sr    = 33'(34'(dv_reg[NDIV].s_q) * 34'(17'(ONE_Q16 - 17'(f))));
    end

    // weights per channel, split multiply by the table value
    always_comb begin
        logic [32:0]      wmax, wmin, wfall, wrise;
        logic [2:0][32:0] w;
        wmax  = {1'b1, 32'b0};
        wmin  = {17'(ONE_Q16 - pr_reg.s), 16'b0};
        wfall = wmax - pr_reg.sf;
        wrise = wmax - pr_reg.sr;
        unique case (pr_reg.sext)
            3'd0:    begin w[0] = wmax;  w[1] = wrise; w[2] = wmin;  end
            3'd1:    begin w[0] = wfall; w[1] = wmax;  w[2] = wmin;  end
            3'd2:    begin w[0] = wmin;  w[1] = wmax;  w[2] = wrise; end
            3'd3:    begin w[0] = wmin;  w[1] = wfall; w[2] = wmax;  end
            3'd4:    begin w[0] = wrise; w[1] = wmin;  w[2] = wmax;  end
            default: begin w[0] = wmax;  w[1] = wmin;  w[2] = wfall; end
        endcase
        ch_next.grey  = pr_reg.grey;
        ch_next.red   = pr_reg.red;
        ch_next.green = pr_reg.green;
        ch_next.blue  = pr_reg.blue;
        for (int c = 0; c < 3; c++) begin
            ch_next.ph[c] = 34'(pr_reg.vg) * 34'(w[c][32:16]);
            ch_next.pl[c] = 33'(pr_reg.vg) * 33'(w[c][15:0]);
        end
    end

    // sum partials, scale by 255, keep bits 55:48
    always_comb begin
        logic [56:0]      x, y;
        logic [2:0][7:0]  ch;
        for (int c = 0; c < 3; c++) begin
            x     = 57'({ch_reg.ph[c], 16'b0}) + 57'(ch_reg.pl[c]);
            y     = (x << 8) - x;
            ch[c] = y[55:48];
        end
        if (ch_reg.grey) begin
            out_next.red_out   = ch_reg.red;
            out_next.green_out = ch_reg.green;
            out_next.blue_out  = ch_reg.blue;
        end else begin
            out_next.red_out   = ch[0];
            out_next.green_out = ch[1];
            out_next.blue_out  = ch[2];
        end
        out_next.grey_passed = ch_reg.grey;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            if (rdy[1]) begin
                v_reg[1] <= v_reg[0] && (in_reg.opcode == OP_PIXEL);
            end
            for (int i = 2; i <= NS; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            in_reg <= s_data;
        end
        if (rdy[1]) begin
            dv_reg[0] <= dv0_next;
        end
        for (int k = 1; k <= NDIV; k++) begin
            if (rdy[k+1]) begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (rdy[NDIV+2]) begin
            pr_reg <= pr_next;
        end
        if (rdy[NDIV+3]) begin
            ch_reg <= ch_next;
        end
        if (rdy[NS]) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            gamma_mem[IDX_W'(in_reg.table_index)] <= in_reg.table_value;
        end
        if (rdy[1]) begin
            mem_rd_reg <= gamma_mem[rd_idx];
        end
    end

endmodule

// File: test/tb_hsv_value_gamma_correct_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_value_gamma_correct_core
// Drives gamma table loads and pixels through the core with random gaps on
// both sides and checks every corrected pixel against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_hsv_value_gamma_correct_core;
    import hvgc_pkg::*;

    localparam int STEPS = TABLE_STEPS_DEF;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hvgc_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hvgc_out_t m_data;

    logic [16:0] gamma_shadow [0:STEPS];
    bit          entry_loaded [0:STEPS];
    hvgc_out_t   pending_pixels [$];
    bit          gaps_on = 1'b1;
    int          fails = 0;
    int          pixels_sent = 0;
    int          loads_sent = 0;
    int          results_seen = 0;

    hsv_value_gamma_correct_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[hsv_value_gamma_correct_core] ERROR");
        $finish;
    end

    function automatic int value_index(input logic [7:0] hi);
        int idx;
        idx = (int'(hi) * STEPS) / 255;
        return (idx > STEPS) ? STEPS : idx;
    endfunction

    function automatic logic [7:0] scale_weight(input logic [63:0] vg, input logic [63:0] w);
        logic [63:0] prod;
        prod = vg * w * 64'd255;
        return prod[55:48];
    endfunction

    function automatic hvgc_out_t correct_pixel(input hvgc_in_t it);
        hvgc_out_t   res;
        logic [7:0]  r, g, b, hi, lo;
        logic [63:0] span, num, sat, frac, pos, vg, wmax, wmin, wfall, wrise;
        logic [63:0] w [3];
        int          sext;
        r = it.red_in; g = it.green_in; b = it.blue_in;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        if (hi == lo) begin
            res.red_out = r; res.green_out = g; res.blue_out = b; res.grey_passed = 1'b1;
            return res;
        end
        span = hi - lo;
        sat = (span << 16) / hi;
        if (r == hi) begin
            if (g == lo) begin sext = 5; num = hi - b; end
            else begin sext = 0; num = g - lo; end
        end else if (g == hi) begin
            if (b == lo) begin sext = 1; num = hi - r; end
            else begin sext = 2; num = b - lo; end
        end else begin
            if (r == lo) begin sext = 3; num = hi - g; end
            else begin sext = 4; num = r - lo; end
        end
        pos = (64'(sext) << 16) + (num << 16) / span;
        if (pos >= (64'd6 << 16)) pos -= (64'd6 << 16);
        sext = int'(pos >> 16);
        frac = pos & 64'hFFFF;
        vg = gamma_shadow[value_index(hi)];
        if (vg > 64'd65536) vg = 64'd65536;
        wmax  = 64'd1 << 32;
        wmin  = wmax - (sat << 16);
        wfall = wmax - sat * frac;
        wrise = wmax - sat * (64'd65536 - frac);
        case (sext)
            0: begin w[0] = wmax;  w[1] = wrise; w[2] = wmin;  end
            1: begin w[0] = wfall; w[1] = wmax;  w[2] = wmin;  end
            2: begin w[0] = wmin;  w[1] = wmax;  w[2] = wrise; end
            3: begin w[0] = wmin;  w[1] = wfall; w[2] = wmax;  end
            4: begin w[0] = wrise; w[1] = wmin;  w[2] = wmax;  end
            default: begin w[0] = wmax; w[1] = wmin; w[2] = wfall; end
        endcase
        res.red_out = scale_weight(vg, w[0]);
        res.green_out = scale_weight(vg, w[1]);
        res.blue_out = scale_weight(vg, w[2]);
        res.grey_passed = 1'b0;
        return res;
    endfunction

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic send_item(input hvgc_in_t it);
        while (gaps_on && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.opcode == OP_PIXEL) begin
            pending_pixels.push_back(correct_pixel(it));
            pixels_sent++;
        end else begin
            loads_sent++;
            if (it.table_index <= STEPS) begin
                gamma_shadow[it.table_index] = it.table_value;
                entry_loaded[it.table_index] = 1'b1;
            end
        end
        @(negedge aclk);
    endtask

    task automatic send_load(input int idx, input int val);
        hvgc_in_t it;
        it = '0;
        it.opcode = OP_LOAD;
        it.table_index = 7'(idx);
        it.table_value = 17'(val);
        it.red_in = 8'($urandom_range(255));
        it.green_in = 8'($urandom_range(255));
        it.blue_in = 8'($urandom_range(255));
        send_item(it);
    endtask

    task automatic send_pixel(input int r, input int g, input int b);
        hvgc_in_t it;
        it.opcode = OP_PIXEL;
        it.table_index = 7'($urandom_range(127));
        it.table_value = 17'($urandom_range(131071));
        it.red_in = 8'(r);
        it.green_in = 8'(g);
        it.blue_in = 8'(b);
        send_item(it);
    endtask

    task automatic drain_pipeline;
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic int random_level;
        case ($urandom_range(5))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(131071, 65537);
            default: return $urandom_range(65536);
        endcase
    endfunction

    task automatic random_pixel;
        int r, g, b, k, hi;
        do begin
            k = $urandom_range(9);
            r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
            if (k == 0) begin g = r; b = r; end
            else if (k == 1) begin r = 255; g = 0; end
            else if (k == 2) begin b = $urandom_range(1) ? 0 : 255; end
            else if (k == 3) begin g = r; end
            hi = (r > g) ? r : g;
            hi = (hi > b) ? hi : b;
        end while (!entry_loaded[value_index(8'(hi))]);
        send_pixel(r, g, b);
    endtask

    always @(negedge aclk) begin
        m_ready <= (gaps_on && $urandom_range(99) < 24) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        hvgc_out_t exp_px;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                fails++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (m_data.red_out !== exp_px.red_out) begin
                    $error("red_out expected %0d got %0d", exp_px.red_out, m_data.red_out);
                    fails++;
                end
                if (m_data.green_out !== exp_px.green_out) begin
                    $error("green_out expected %0d got %0d", exp_px.green_out, m_data.green_out);
                    fails++;
                end
                if (m_data.blue_out !== exp_px.blue_out) begin
                    $error("blue_out expected %0d got %0d", exp_px.blue_out, m_data.blue_out);
                    fails++;
                end
                if (m_data.grey_passed !== exp_px.grey_passed) begin
                    $error("grey_passed expected %0d got %0d",
                           exp_px.grey_passed, m_data.grey_passed);
                    fails++;
                end
            end
        end
    end

    task automatic test_directed_loads;
        send_load(0, 0);
        send_load(50, 32768);
        send_load(100, 65536);
        send_load(101, 777);
        send_load(127, 131071);
        send_load(100, 131071);
    endtask

    task automatic test_directed_pixels;
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(1, 2, 0);
        send_pixel(255, 0, 0);
        send_pixel(255, 255, 0);
        send_pixel(255, 0, 255);
        send_pixel(0, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(0, 0, 255);
        send_pixel(255, 0, 128);
        send_pixel(128, 0, 255);
        send_pixel(0, 128, 128);
        send_pixel(128, 64, 0);
        send_pixel(20, 128, 90);
        send_pixel(90, 30, 128);
        drain_pipeline();
    endtask

    task automatic test_table_fill;
        int order [STEPS + 1];
        int j, t;
        for (int i = 0; i <= STEPS; i++) order[i] = i;
        for (int i = STEPS; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        for (int i = 0; i <= STEPS; i++) begin
            send_load(order[i], random_level());
            if ($urandom_range(9) == 0) send_load($urandom_range(127, STEPS + 1), random_level());
            if (i > 10 && $urandom_range(2) == 0) random_pixel();
        end
    endtask

    task automatic test_random_mix;
        for (int n = 0; n < 800; n++) begin
            if ($urandom_range(99) < 12) send_load($urandom_range(127), random_level());
            else random_pixel();
            if (n == 400) drain_pipeline();
        end
        drain_pipeline();
    endtask

    task automatic test_unbroken_stream;
        gaps_on = 1'b0;
        for (int n = 0; n < 200; n++) begin
            if ($urandom_range(9) == 0) send_load($urandom_range(STEPS), random_level());
            else random_pixel();
        end
        drain_pipeline();
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i <= STEPS; i++) begin
            gamma_shadow[i] = '0;
            entry_loaded[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_loads();
        test_directed_pixels();
        test_table_fill();
        test_random_mix();
        test_unbroken_stream();
        $display("covered %0d pixels and %0d table loads, %0d results checked",
                 pixels_sent, loads_sent, results_seen);
        $display("grey, extreme, full-sextant carry, saturated and ignored loads included");
        if (fails == 0) begin
            $display("[hsv_value_gamma_correct_core] OK");
        end else begin
            $display("[hsv_value_gamma_correct_core] ERROR");
        end
        $finish;
    end

endmodule
